// ----- rtl/token_lexer_fsm_core_assert.svh -----
// Assertion macros shared by the checker files of the token lexer.
// Each macro samples on the rising edge of clk and is disabled during rst.
`ifndef TOKEN_LEXER_FSM_CORE_ASSERT_SVH
`define TOKEN_LEXER_FSM_CORE_ASSERT_SVH

// Combinational implication checked at every clock edge.
`define TLF_ASSERT_SAME(lbl, pre, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (cond)) else $error(msg);

// Condition required in the cycle after the antecedent.
`define TLF_ASSERT_NEXT(lbl, pre, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (cond)) else $error(msg);

`endif

// ----- rtl/tlf_pkg.sv -----
// Shared types and constants for the token lexer.
// Used by the front, queue, back, top level and checker; no dependencies.
`default_nettype none

package tlf_pkg;

  typedef enum logic [3:0] {
    TOK_IDENT  = 4'd0,
    TOK_CONST  = 4'd1,
    TOK_ASSIGN = 4'd2,
    TOK_LE     = 4'd3,
    TOK_NE     = 4'd4,
    TOK_GE     = 4'd5,
    TOK_BRACE  = 4'd6,
    TOK_PAREN  = 4'd7,
    TOK_EOF    = 4'd8,
    TOK_ERROR  = 4'd9
  } token_t;

  typedef enum logic [9:0] {
    M_START = 10'b00_0000_0001,
    M_IDENT = 10'b00_0000_0010,
    M_CONST = 10'b00_0000_0100,
    M_COLON = 10'b00_0000_1000,
    M_LT    = 10'b00_0001_0000,
    M_GT    = 10'b00_0010_0000,
    M_LPAR  = 10'b00_0100_0000,
    M_BRACE = 10'b00_1000_0000,
    M_PCOM  = 10'b01_0000_0000,
    M_PSTAR = 10'b10_0000_0000
  } lex_mode_t;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_RPAREN = 8'h29;

  // Queue between front and back.
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // Tokens caused by one byte: tok0 always, tok1 only when two is set.
  typedef struct packed {
    logic   two;
    token_t tok0;
    token_t tok1;
  } entry_t;

endpackage

`default_nettype wire

// ----- rtl/tlf_front.sv -----
// Front end of the token lexer: accepts bytes, keeps the lexer mode and
// forms the token group each byte causes. Depends on tlf_pkg.
`default_nettype none

module tlf_front (
  input  logic            clk,
  input  logic            rst,
  input  logic [7:0]      char_code,
  input  logic            char_valid,
  output logic            char_ready,
  input  logic            q_full,
  output logic            push,
  output tlf_pkg::entry_t push_entry
);
  import tlf_pkg::*;

  lex_mode_t mode;
  lex_mode_t mode_next;
  lex_mode_t direct_mode;
  lex_mode_t start_mode;
  logic      accept;
  logic      is_let;
  logic      is_dig;
  logic      pre_emit;
  token_t    pre_tok;
  logic      run_start;
  logic      start_emit;
  token_t    start_tok;
  logic      s_emit;

  assign char_ready = !q_full;
  assign accept     = char_valid && char_ready;

  assign is_let = ((char_code >= 8'h41) && (char_code <= 8'h5A)) ||
                  ((char_code >= 8'h61) && (char_code <= 8'h7A));
  assign is_dig = (char_code >= 8'h30) && (char_code <= 8'h39);

  // Handling of a byte from the start mode.
  always_comb begin
    start_emit = 1'b0;
    start_tok  = TOK_ERROR;
    start_mode = M_START;
    if (is_let) begin
      start_mode = M_IDENT;
    end else if (is_dig) begin
      start_mode = M_CONST;
    end else if (char_code == CH_COLON) begin
      start_mode = M_COLON;
    end else if (char_code == CH_LT) begin
      start_mode = M_LT;
    end else if (char_code == CH_GT) begin
      start_mode = M_GT;
    end else if (char_code == CH_LPAREN) begin
      start_mode = M_LPAR;
    end else if (char_code == CH_LBRACE) begin
      start_mode = M_BRACE;
    end else if (char_code == CH_DOLLAR) begin
      start_emit = 1'b1;
      start_tok  = TOK_EOF;
    end else begin
      start_emit = 1'b1;
      start_tok  = TOK_ERROR;
    end
  end

  // Pending-token handling for the current mode. When run_start is set the
  // byte is then handled again from the start mode.
  always_comb begin
    pre_emit    = 1'b0;
    pre_tok     = TOK_ERROR;
    run_start   = 1'b0;
    direct_mode = mode;
    case (mode)
      M_IDENT: begin
        if (!(is_let || is_dig)) begin
          pre_emit  = 1'b1;
          pre_tok   = TOK_IDENT;
          run_start = 1'b1;
        end
      end
      M_CONST: begin
        if (!is_dig) begin
          pre_emit  = 1'b1;
          pre_tok   = TOK_CONST;
          run_start = 1'b1;
        end
      end
      M_COLON: begin
        pre_emit = 1'b1;
        if (char_code == CH_EQUAL) begin
          pre_tok     = TOK_ASSIGN;
          direct_mode = M_START;
        end else begin
          run_start = 1'b1;
        end
      end
      M_LT: begin
        pre_emit = 1'b1;
        if (char_code == CH_EQUAL) begin
          pre_tok     = TOK_LE;
          direct_mode = M_START;
        end else if (char_code == CH_GT) begin
          pre_tok     = TOK_NE;
          direct_mode = M_START;
        end else begin
          run_start = 1'b1;
        end
      end
      M_GT: begin
        pre_emit = 1'b1;
        if (char_code == CH_EQUAL) begin
          pre_tok     = TOK_GE;
          direct_mode = M_START;
        end else begin
          run_start = 1'b1;
        end
      end
      M_LPAR: begin
        if (char_code == CH_STAR) begin
          direct_mode = M_PCOM;
        end else begin
          pre_emit  = 1'b1;
          run_start = 1'b1;
        end
      end
      M_BRACE: begin
        if (char_code == CH_RBRACE) begin
          pre_emit    = 1'b1;
          pre_tok     = TOK_BRACE;
          direct_mode = M_START;
        end else if (char_code == CH_DOLLAR) begin
          // Unterminated comment: error, then eof from the start mode.
          pre_emit  = 1'b1;
          run_start = 1'b1;
        end
      end
      M_PCOM, M_PSTAR: begin
        if (char_code == CH_DOLLAR) begin
          pre_emit  = 1'b1;
          run_start = 1'b1;
        end else if ((mode == M_PSTAR) && (char_code == CH_RPAREN)) begin
          pre_emit    = 1'b1;
          pre_tok     = TOK_PAREN;
          direct_mode = M_START;
        end else if (char_code == CH_STAR) begin
          direct_mode = M_PSTAR;
        end else begin
          direct_mode = M_PCOM;
        end
      end
      default: begin
        run_start = 1'b1;
      end
    endcase
  end

  assign s_emit    = run_start && start_emit;
  assign mode_next = run_start ? start_mode : direct_mode;

  assign push            = accept && (pre_emit || s_emit);
  assign push_entry.two  = pre_emit && s_emit;
  assign push_entry.tok0 = pre_emit ? pre_tok : start_tok;
  assign push_entry.tok1 = start_tok;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_START;
    end else if (accept) begin
      mode <= mode_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tlf_queue.sv -----
// Short queue of token groups between the lexer front and back.
// Depends on tlf_pkg for the entry type and depth.
`default_nettype none

module tlf_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tlf_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output tlf_pkg::entry_t head
);
  import tlf_pkg::*;

  entry_t             slots [QDepth];
  logic [QPtrW-1:0]   wr_ptr;
  logic [QPtrW-1:0]   rd_ptr;
  logic [QCntW-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full       = (count == QCntW'(QDepth));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tlf_back.sv -----
// Back end of the token lexer: splits queued groups into single tokens and
// holds them in the output register. Depends on tlf_pkg.
`default_nettype none

module tlf_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  tlf_pkg::entry_t head,
  output logic            pop,
  output logic            tok_valid,
  input  logic            tok_ready,
  output logic [3:0]      token,
  output logic            last
);
  import tlf_pkg::*;

  logic half;
  logic load;

  assign load = head_valid && (!tok_valid || tok_ready);
  assign pop  = load && (half || !head.two);

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
      half      <= 1'b0;
    end else if (load) begin
      tok_valid <= 1'b1;
      half      <= head.two && !half;
    end else if (tok_ready) begin
      tok_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      token <= half ? head.tok1 : head.tok0;
      last  <= half || !head.two;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/token_lexer_fsm_core.sv -----
// Token lexer top level: one input byte is a word on the char channel, each
// token is a word on the tok channel. A byte passes through a queue slot to
// the output register; a byte that causes two tokens delivers them in turn.
// Throughput is one byte per cycle while the queue is not full, and the queue
// fills when tok_ready stalls or bytes outpace the one-token-per-cycle output.
// Synchronous active-high rst returns the lexer to the start mode and empties.
`default_nettype none

module token_lexer_fsm_core (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] char_code,
  input  logic       char_valid,
  output logic       char_ready,
  output logic [3:0] token,
  output logic       last,
  output logic       tok_valid,
  input  logic       tok_ready
);
  import tlf_pkg::*;

  // The front updates the lexer mode for every accepted byte in the same
  // cycle, independent of the output side; only the queue filling up stalls
  // it. Each byte that causes tokens writes one queue entry holding one or
  // two token codes.
  logic   push;
  entry_t push_entry;
  logic   q_full;

  // The back drains the queue one token per cycle into the output register,
  // so a full output register stalls only the back while the front keeps
  // accepting bytes until the queue is full.
  logic   pop;
  logic   head_valid;
  entry_t head;

  tlf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_code  (char_code),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  tlf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  tlf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .tok_valid  (tok_valid),
    .tok_ready  (tok_ready),
    .token      (token),
    .last       (last)
  );

endmodule

`default_nettype wire

// ----- rtl/tlf_checker.sv -----
// Port-level checker for the token lexer, bound to the top level.
// Depends on tlf_pkg and token_lexer_fsm_core_assert.svh.
`default_nettype none
`include "token_lexer_fsm_core_assert.svh"

module tlf_checker (
  input logic       clk,
  input logic       rst,
  input logic [7:0] char_code,
  input logic       char_valid,
  input logic       char_ready,
  input logic [3:0] token,
  input logic       last,
  input logic       tok_valid,
  input logic       tok_ready
);
  import tlf_pkg::*;

  // Only defined token codes leave the block.
  `TLF_ASSERT_SAME(a_tok_range, tok_valid, token <= TOK_ERROR, "token code out of range")

  // End of input always closes the group of its byte.
  `TLF_ASSERT_SAME(a_eof_last, tok_valid && (token == TOK_EOF), last, "eof not last")

  // Only a finished identifier, constant or error can be followed by a
  // second token from the same byte.
  `TLF_ASSERT_SAME(a_first_kind, tok_valid && !last,
                   (token == TOK_IDENT) || (token == TOK_CONST) || (token == TOK_ERROR),
                   "unexpected token ahead of a second one")

  // A stalled token word holds.
  `TLF_ASSERT_NEXT(a_out_hold, tok_valid && !tok_ready,
                   tok_valid && $stable(token) && $stable(last), "stalled token changed")

  // A stalled byte word holds until it is taken.
  `TLF_ASSERT_NEXT(a_in_hold, char_valid && !char_ready,
                   char_valid && $stable(char_code), "stalled byte changed")

endmodule

bind token_lexer_fsm_core tlf_checker u_tlf_checker (.*);

`default_nettype wire
